### hdl/cpfc_pkg.sv
package cpfc_pkg;

  localparam int unsigned AddrW   = 7;
  localparam int unsigned ValueW  = 11;
  localparam int unsigned CwW     = 16;
  localparam int unsigned CrcW    = 3;
  localparam int unsigned DataW   = 24;
  localparam int unsigned DivW    = DataW + CrcW;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 40;

  localparam logic [1:0] FillBits = 2'b11;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef struct packed {
    logic [InDataW-AddrW-ValueW-CwW-1:0] pad;
    logic [CwW-1:0]                      read_codeword;
    logic [ValueW-1:0]                   write_value;
    logic [AddrW-1:0]                    target_reg;
  } in_data_t;

  typedef struct packed {
    logic [OutDataW-8-CwW-ValueW-1-1:0] pad;
    logic                               crc_ok;
    logic [ValueW-1:0]                  read_value;
    logic [CwW-1:0]                     frame_word;
    logic [7:0]                         addr_byte;
  } out_data_t;

  // x^k mod (x^3 + x + 1) repeats with period 7
  localparam logic [CrcW-1:0] XPowRem [7] = '{
    3'd1, 3'd2, 3'd4, 3'd3, 3'd6, 3'd7, 3'd5
  };

  function automatic logic [CrcW-1:0] crc3_rem(input logic [DivW-1:0] w);
    logic [CrcW-1:0] r;
    r = '0;
    for (int k = 0; k < DivW; k++) begin
      if (w[k]) begin
        r = r ^ XPowRem[k % 7];
      end
    end
    return r;
  endfunction

endpackage

### hdl/crc_protected_register_frame_codec.sv
// Transfers pass the input register, then the result register. Throughput:
// one item per cycle while the master side accepts; the two registers form
// a two-stage pipeline, each stage advancing when the stage after it is free.
// Reset (rst_ni low, asynchronous): both stages empty, device address 0.
module crc_protected_register_frame_codec (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // target_reg, write_value, read_codeword, zero fill
  input  logic [cpfc_pkg::InDataW-1:0]  s_axis_tdata,
  // op
  input  logic                     s_axis_tuser,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // addr_byte, frame_word, read_value, crc_ok, zero fill
  output logic [cpfc_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [cpfc_pkg::AddrW-1:0]    cfg_data_i
);
  import cpfc_pkg::*;

  logic [AddrW-1:0] dev_addr_q;
  logic             in_valid_q;
  in_data_t         in_data_q;
  op_e              in_op_q;
  logic             out_valid_q;
  out_data_t        out_data_q, out_data_d;
  logic             out_adv;
  logic             in_adv;
  logic [DivW-1:0]  div_word;
  logic [CrcW-1:0]  rem;

  assign cfg_ready_o   = 1'b1;
  assign out_adv       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_adv;
  assign in_adv        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= '0;
    end else if (cfg_valid_i) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      in_data_q <= in_data_t'(s_axis_tdata);
      in_op_q   <= op_e'(s_axis_tuser);
    end
    if (out_adv && in_valid_q) begin
      out_data_q <= out_data_d;
    end
  end

  always_comb begin
    if (in_op_q == OP_WRITE) begin
      div_word = {in_data_q.target_reg, 1'b0, in_data_q.write_value[10:3], 5'b0,
                  in_data_q.write_value[2:0], 3'b0};
    end else begin
      div_word = {8'b0, in_data_q.read_codeword[15:8], 5'b0,
                  in_data_q.read_codeword[7:5], in_data_q.read_codeword[2:0]};
    end
    rem = crc3_rem(div_word);

    out_data_d = '0;
    if (in_op_q == OP_WRITE) begin
      out_data_d.addr_byte  = {^dev_addr_q, in_data_q.target_reg};
      out_data_d.frame_word = {in_data_q.write_value, FillBits, rem};
    end else begin
      out_data_d.read_value = in_data_q.read_codeword[15:5];
      out_data_d.crc_ok     = (rem == '0);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### hdl/cpfc_checker.sv
module cpfc_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     s_axis_tvalid,
  input logic                     s_axis_tready,
  input logic                     m_axis_tvalid,
  input logic                     m_axis_tready,
  input logic [cpfc_pkg::OutDataW-1:0] m_axis_tdata
);
  import cpfc_pkg::*;

  out_data_t res;
  assign res = out_data_t'(m_axis_tdata);

  // stalled result holds
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a transfer followed by a ready sink yields a valid result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready |=> m_axis_tvalid)
    else $error("result missing two cycles after transfer");

  // empty output stage never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // read results carry no write frame
  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (res.read_value != '0 || res.crc_ok)
      |-> res.addr_byte == '0 && res.frame_word == '0)
    else $error("read result with write fields set");

  // write frames carry the fill bits
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.frame_word != '0 |-> res.frame_word[4:3] == FillBits)
    else $error("write frame without fill bits");

endmodule

bind crc_protected_register_frame_codec cpfc_checker u_cpfc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/tb.sv
module tb;
  import cpfc_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseItems  = 300;
  localparam int unsigned DrainCycles = 8;

  typedef struct {
    op_e         op;
    logic [6:0]  target_reg;
    logic [10:0] write_value;
    logic [15:0] read_codeword;
    bit          typed;
    logic [7:0]  want_addr;
    logic [15:0] want_frame;
    logic [10:0] want_value;
    logic        want_ok;
  } frame_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;   // target_reg, write_value, read_codeword, zero fill
  logic                s_axis_tuser;   // op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;   // addr_byte, frame_word, read_value, crc_ok, zero fill
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [AddrW-1:0]    cfg_data_i;

  logic [AddrW-1:0] dev_addr;
  out_data_t        frame_q[$];
  int unsigned      err_count;
  int unsigned      cycle_count;
  int unsigned      sender_idle_pct;
  int unsigned      rx_stall_pct;
  int unsigned      hold_left;

  frame_row_t directed_rows [13] = '{
    '{OP_WRITE, 7'h00, 11'h000, 16'h0000, 1'b1, 8'h00, 16'h0018, 11'h000, 1'b0},
    '{OP_WRITE, 7'h7F, 11'h7FF, 16'hFFFF, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_WRITE, 7'h7F, 11'h000, 16'h0000, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_WRITE, 7'h00, 11'h7FF, 16'h0000, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_WRITE, 7'h55, 11'h555, 16'hAAAA, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_WRITE, 7'h2A, 11'h2AA, 16'h5555, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_READ,  7'h7F, 11'h7FF, 16'h0000, 1'b1, 8'h00, 16'h0000, 11'h000, 1'b1},
    '{OP_READ,  7'h00, 11'h000, 16'h0018, 1'b1, 8'h00, 16'h0000, 11'h000, 1'b1},
    '{OP_READ,  7'h00, 11'h000, 16'h0001, 1'b1, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_READ,  7'h00, 11'h000, 16'h0007, 1'b1, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_READ,  7'h00, 11'h000, 16'hFFFF, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_READ,  7'h00, 11'h000, 16'hFFE0, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0},
    '{OP_READ,  7'h00, 11'h000, 16'h0020, 1'b0, 8'h00, 16'h0000, 11'h000, 1'b0}
  };

  crc_protected_register_frame_codec u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // MSB-first long division by x^3+x+1
  function automatic logic [CrcW-1:0] poly_mod3(input logic [26:0] dividend);
    logic [26:0] w;
    w = dividend;
    for (int i = 26; i >= 3; i--) begin
      if (w[i]) begin
        w = w ^ (27'hB << (i - 3));
      end
    end
    return w[2:0];
  endfunction

  function automatic out_data_t predict_frame(op_e op, logic [6:0] ra, logic [10:0] val,
                                              logic [15:0] cw);
    out_data_t   r;
    logic [23:0] data;
    r = '0;
    if (op == OP_WRITE) begin
      data = {ra, 1'b0, val[10:3], 5'b0, val[2:0]};
      r.addr_byte  = {^dev_addr, ra};
      r.frame_word = {val, FillBits, poly_mod3({data, 3'b000})};
    end else begin
      data = {8'b0, cw[15:8], 5'b0, cw[7:5]};
      r.read_value = cw[15:5];
      r.crc_ok     = (poly_mod3({data, cw[2:0]}) == '0);
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    err_count++;
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_frame(op_e op, logic [6:0] ra, logic [10:0] val, logic [15:0] cw,
                            bit typed, out_data_t want);
    in_data_t d;
    d = '0;
    d.target_reg    = ra;
    d.write_value   = val;
    d.read_codeword = cw;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = d;
    s_axis_tuser  = op;
    do @(posedge clk_i); while (!s_axis_tready);
    frame_q.push_back(typed ? want : predict_frame(op, ra, val, cw));
    @(negedge clk_i);
  endtask

  task automatic drain_and_configure(logic [AddrW-1:0] value);
    s_axis_tvalid = 1'b0;
    while (frame_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    dev_addr = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic run_random(int unsigned idle, int unsigned stall, int unsigned hold);
    op_e         op;
    logic [6:0]  ra;
    logic [10:0] val;
    logic [15:0] cw;
    out_data_t   good;
    int unsigned sel;
    sender_idle_pct = idle;
    rx_stall_pct    = stall;
    hold_left       = hold;
    for (int n = 0; n < PhaseItems; n++) begin
      op  = op_e'($urandom_range(1));
      ra  = 7'($urandom_range(127));
      val = 11'($urandom_range(2047));
      cw  = 16'($urandom_range(65535));
      if (op == OP_READ) begin
        sel = $urandom_range(9);
        // some valid codewords, some with one bit flipped, the rest random
        if (sel < 6) begin
          good = predict_frame(OP_WRITE, 7'h00, val, 16'h0000);
          cw   = good.frame_word;
          cw[4:3] = 2'($urandom_range(3));
          if (sel >= 4) begin
            cw = cw ^ (16'h1 << $urandom_range(15));
          end
        end
      end
      send_frame(op, ra, val, cw, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    out_data_t got;
    out_data_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (frame_q.size() == 0) begin
        report_mismatch("result with nothing pending, frame_word", got.frame_word, '0);
      end else begin
        want = frame_q.pop_front();
        if (got.addr_byte != want.addr_byte)
          report_mismatch("addr_byte", 16'(got.addr_byte), 16'(want.addr_byte));
        if (got.frame_word != want.frame_word)
          report_mismatch("frame_word", got.frame_word, want.frame_word);
        if (got.read_value != want.read_value)
          report_mismatch("read_value", 16'(got.read_value), 16'(want.read_value));
        if (got.crc_ok != want.crc_ok)
          report_mismatch("crc_ok", 16'(got.crc_ok), 16'(want.crc_ok));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    out_data_t want;
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = 1'b0;
    m_axis_tready   = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    dev_addr        = '0;
    err_count       = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    rx_stall_pct    = 0;
    hold_left       = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset device address (parity 0)
    foreach (directed_rows[i]) begin
      want = '0;
      want.addr_byte  = directed_rows[i].want_addr;
      want.frame_word = directed_rows[i].want_frame;
      want.read_value = directed_rows[i].want_value;
      want.crc_ok     = directed_rows[i].want_ok;
      send_frame(directed_rows[i].op, directed_rows[i].target_reg,
                 directed_rows[i].write_value, directed_rows[i].read_codeword,
                 directed_rows[i].typed, want);
    end

    drain_and_configure(7'h7F);
    run_random(0, 0, 0);
    drain_and_configure(7'h00);
    run_random(67, 0, 0);
    drain_and_configure(7'($urandom_range(127)));
    run_random(0, 67, 0);
    drain_and_configure(7'h01);
    run_random(16, 16, 0);
    // long receiver hold-off fills the pipeline and backs up the input
    drain_and_configure(7'h03);
    run_random(0, 0, 60);

    s_axis_tvalid = 1'b0;
    while (frame_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
hdl/cpfc_pkg.sv
hdl/crc_protected_register_frame_codec.sv
hdl/cpfc_checker.sv
tb/tb.sv
